/* hdl/hex_line_ram_loader_unit_macros.svh */
// Assertion helpers for the loader
`ifndef HEX_LINE_RAM_LOADER_UNIT_MACROS_SVH
`define HEX_LINE_RAM_LOADER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define HLRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define HLRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/hlrl_pkg.sv */
package hlrl_pkg;

	localparam int unsigned ADDR_W = 16;
	localparam int unsigned SIZE_W = 17;
	localparam int unsigned OFFS_W = 17;

	localparam logic [SIZE_W-1:0] MEM_BYTES_RESET = 17'h10000;
	localparam logic [SIZE_W-1:0] MEM_BYTES_MAX   = 17'h10000;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_F     = 8'h46;

	localparam logic [2:0] NUM_ADDR_DIGITS = 3'd4;

	localparam logic [2:0] ST_NONE     = 3'd0;
	localparam logic [2:0] ST_LINE_OK  = 3'd1;
	localparam logic [2:0] ST_PROG_END = 3'd2;
	localparam logic [2:0] ST_ADDR_ERR = 3'd3;
	localparam logic [2:0] ST_SYNTAX   = 3'd4;

	typedef enum logic [1:0] {
		PH_ADDR,
		PH_DATA,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// ASCII hex digit decode; anything else reads as 0 and not ok
	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b1;
		h.val = 4'd0;
		if (c >= 8'd48 && c <= 8'd57) begin
			h.val = 4'(c - 8'd48);
		end else if (c >= 8'd65 && c <= 8'd70) begin
			h.val = 4'(c - 8'd55);
		end else if (c >= 8'd97 && c <= 8'd102) begin
			h.val = 4'(c - 8'd87);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

/* hdl/hex_line_ram_loader_unit.sv */
// Streaming loader for text lines "HHLL: HH HH ...". One character item enters per clock
// unless in_stall is high and produces exactly one result item (write strobe, address,
// data, status, line address) via the input and result registers; the sustained rate of
// one item per cycle is set by the parser state loop through the hex decode, the 18-bit
// start-plus-offset add and the compare against the memory size. An output register
// holds a stalled result while an empty input register can still take the next character.
// A memory size above 65536 acts as 65536; cfg_ready is always high and the memory
// size should only be written while no item is in flight.
module hex_line_ram_loader_unit
	import hlrl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        char_in,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              write_en,
	output logic [ADDR_W-1:0] write_addr,
	output logic [7:0]        write_data,
	output logic [2:0]        status,
	output logic [ADDR_W-1:0] line_addr,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SIZE_W-1:0] cfg_data
);

`include "hex_line_ram_loader_unit_macros.svh"

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              advance;

	logic [SIZE_W-1:0] mem_bytes_q;
	logic [SIZE_W-1:0] limit;

	phase_t            phase_q,       phase_d;
	logic [2:0]        char_index_q,  char_index_d;
	logic [ADDR_W-1:0] addr_accum_q,  addr_accum_d;
	logic              addr_stopped_q, addr_stopped_d;
	logic              all_f_q,       all_f_d;
	logic [3:0]        high_nibble_q, high_nibble_d;
	logic              pending_q,     pending_d;
	logic [OFFS_W-1:0] byte_offset_q, byte_offset_d;

	logic              out_valid_q;
	logic              wr_en_d,   wr_en_q;
	logic [ADDR_W-1:0] wr_addr_d, wr_addr_q;
	logic [7:0]        wr_data_d, wr_data_q;
	logic [2:0]        status_d,  status_q;
	logic [ADDR_W-1:0] laddr_d,   laddr_q;

	hex_t              hx;
	logic              term;
	logic              restart;
	logic [ADDR_W-1:0] acc_new;
	logic [OFFS_W:0]   wr_sum;
	logic              wr_oob;
	logic              acc_oob;
	logic              cur_oob;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	assign limit = (mem_bytes_q > MEM_BYTES_MAX) ? MEM_BYTES_MAX : mem_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_bytes_q <= MEM_BYTES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mem_bytes_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
		end
	end

	always_comb begin
		hx      = hex_decode(char_s1);
		term    = (char_s1 == CH_LF) || (char_s1 == CH_NUL);
		acc_new = (!addr_stopped_q && hx.ok) ? {addr_accum_q[ADDR_W-5:0], hx.val}
		                                     : addr_accum_q;
		wr_sum  = {2'b00, addr_accum_q} + {1'b0, byte_offset_q};
		wr_oob  = wr_sum >= {1'b0, limit};
		acc_oob = {1'b0, acc_new} >= limit;
		cur_oob = {1'b0, addr_accum_q} >= limit;

		phase_d        = phase_q;
		char_index_d   = char_index_q;
		addr_accum_d   = addr_accum_q;
		addr_stopped_d = addr_stopped_q;
		all_f_d        = all_f_q;
		high_nibble_d  = high_nibble_q;
		pending_d      = pending_q;
		byte_offset_d  = byte_offset_q;
		restart        = 1'b0;

		wr_en_d   = 1'b0;
		wr_addr_d = '0;
		wr_data_d = '0;
		status_d  = ST_NONE;
		laddr_d   = '0;

		case (phase_q)
			PH_ADDR: begin
				if (term) begin
					status_d = (char_index_q < NUM_ADDR_DIGITS && cur_oob) ? ST_ADDR_ERR
					                                                       : ST_SYNTAX;
					restart  = 1'b1;
				end else if (char_index_q < NUM_ADDR_DIGITS) begin
					addr_accum_d   = acc_new;
					addr_stopped_d = addr_stopped_q || !hx.ok;
					all_f_d        = all_f_q && (char_s1 == CH_F);
					char_index_d   = char_index_q + 3'd1;
					if (char_index_d == NUM_ADDR_DIGITS) begin
						if (all_f_d) begin
							status_d = ST_PROG_END;
							phase_d  = PH_SKIP;
						end else if (acc_oob) begin
							status_d = ST_ADDR_ERR;
							phase_d  = PH_SKIP;
						end
					end
				end else if (char_s1 == CH_COLON) begin
					phase_d = PH_DATA;
				end else begin
					status_d = ST_SYNTAX;
					phase_d  = PH_SKIP;
				end
			end
			PH_DATA: begin
				if (term) begin
					// a lone trailing digit is flushed as the high nibble
					if (pending_q && wr_oob) begin
						status_d = ST_ADDR_ERR;
					end else begin
						if (pending_q) begin
							wr_en_d   = 1'b1;
							wr_addr_d = wr_sum[ADDR_W-1:0];
							wr_data_d = {high_nibble_q, 4'd0};
						end
						status_d = ST_LINE_OK;
						laddr_d  = addr_accum_q;
					end
					restart = 1'b1;
				end else if (pending_q) begin
					pending_d = 1'b0;
					if (wr_oob) begin
						status_d = ST_ADDR_ERR;
						phase_d  = PH_SKIP;
					end else begin
						wr_en_d       = 1'b1;
						wr_addr_d     = wr_sum[ADDR_W-1:0];
						wr_data_d     = {high_nibble_q, hx.val};
						byte_offset_d = byte_offset_q + OFFS_W'(1);
					end
				end else if (char_s1 != CH_SPACE) begin
					high_nibble_d = hx.val;
					pending_d     = 1'b1;
				end
			end
			default: begin
				if (term) begin
					restart = 1'b1;
				end
			end
		endcase

		if (restart) begin
			phase_d        = PH_ADDR;
			char_index_d   = '0;
			addr_accum_d   = '0;
			addr_stopped_d = 1'b0;
			all_f_d        = 1'b1;
			high_nibble_d  = '0;
			pending_d      = 1'b0;
			byte_offset_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_ADDR;
			char_index_q   <= '0;
			addr_accum_q   <= '0;
			addr_stopped_q <= 1'b0;
			all_f_q        <= 1'b1;
			high_nibble_q  <= '0;
			pending_q      <= 1'b0;
			byte_offset_q  <= '0;
		end else if (valid_s1 && advance) begin
			phase_q        <= phase_d;
			char_index_q   <= char_index_d;
			addr_accum_q   <= addr_accum_d;
			addr_stopped_q <= addr_stopped_d;
			all_f_q        <= all_f_d;
			high_nibble_q  <= high_nibble_d;
			pending_q      <= pending_d;
			byte_offset_q  <= byte_offset_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			wr_en_q   <= wr_en_d;
			wr_addr_q <= wr_addr_d;
			wr_data_q <= wr_data_d;
			status_q  <= status_d;
			laddr_q   <= laddr_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign write_en   = wr_en_q;
	assign write_addr = wr_addr_q;
	assign write_data = wr_data_q;
	assign status     = status_q;
	assign line_addr  = laddr_q;

	`HLRL_ASSERT_NOW(a_write_status, clk, arst_n, out_valid && write_en,
		status == ST_NONE || status == ST_LINE_OK, "write item with error status")

	`HLRL_ASSERT_NOW(a_line_addr_only_ok, clk, arst_n, out_valid && status != ST_LINE_OK,
		line_addr == '0, "line address without line ok")

	`HLRL_ASSERT_NOW(a_index_range, clk, arst_n, phase_q == PH_ADDR,
		char_index_q <= NUM_ADDR_DIGITS, "address digit index past four")

	`HLRL_ASSERT_NOW(a_index_after_addr, clk, arst_n, phase_q != PH_ADDR,
		char_index_q == NUM_ADDR_DIGITS, "data or skip phase before four address characters")

	`HLRL_ASSERT_NEXT(a_no_pending_outside_data, clk, arst_n,
		valid_s1 && advance && phase_d == PH_ADDR, !pending_q,
		"nibble pending after line restart")

endmodule
